// ===== hdl/cpfa_pkg.sv =====
// Shared types and constants of the contiguous page frame allocator.
package cpfa_pkg;

    localparam int NUM_FRAMES_DEF = 64;

    localparam int SIZE_W   = 23;
    localparam int ADDR_W   = 22;
    localparam int PAGE_W   = 16;
    localparam int FCNT_W   = 7;
    localparam int START_W  = 6;
    localparam int CFG_IW   = 2;
    localparam int CFG_DW   = 16;

    localparam logic [PAGE_W-1:0] PAGE_BYTES_RST  = 16'd4096;
    localparam logic [FCNT_W-1:0] FRAME_COUNT_RST = 7'd64;

    localparam logic [CFG_IW-1:0] REG_PAGE_BYTES  = 2'd0;
    localparam logic [CFG_IW-1:0] REG_FRAME_COUNT = 2'd1;

    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    typedef struct packed {
        logic              opcode;
        logic [SIZE_W-1:0] request_size;
        logic [ADDR_W-1:0] release_address;
    } t_req;

    typedef struct packed {
        logic               success;
        logic [START_W-1:0] start_frame;
    } t_rsp;

    typedef struct packed {
        logic              start;
        logic [SIZE_W-1:0] dividend;
        logic [PAGE_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [SIZE_W-1:0] quot;
        logic              rem_nz;
    } t_div_rsp;

endpackage

// ===== hdl/cpfa_div.sv =====
// Restoring divider, one quotient bit per cycle.
module cpfa_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  cpfa_pkg::t_div_req i_req,
    output cpfa_pkg::t_div_rsp o_rsp
);
    import cpfa_pkg::*;

    localparam int CNT_W = $clog2(SIZE_W);

    logic [SIZE_W-1:0] r_quo;
    logic [PAGE_W-1:0] r_rem;
    logic [PAGE_W-1:0] r_dvs;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [PAGE_W:0]   sh;
    logic              ge;
    logic [PAGE_W:0]   diff;

    always_comb begin
        sh   = {r_rem, r_quo[SIZE_W-1]};
        ge   = sh >= {1'b0, r_dvs};
        diff = sh - {1'b0, r_dvs};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_quo  <= i_req.dividend;
                r_rem  <= '0;
                r_dvs  <= i_req.divisor;
                r_cnt  <= CNT_W'(SIZE_W - 1);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_quo <= {r_quo[SIZE_W-2:0], ge};
                r_rem <= ge ? diff[PAGE_W-1:0] : sh[PAGE_W-1:0];
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.quot   = r_quo;
    assign o_rsp.rem_nz = r_rem != '0;

endmodule

// ===== hdl/cpfa_bitmap.sv =====
// Frame used/free bitmap: one-bit synchronous RAM, one write and one read port.
module cpfa_bitmap #(
    parameter int DEPTH = cpfa_pkg::NUM_FRAMES_DEF,
    parameter int AW    = $clog2(cpfa_pkg::NUM_FRAMES_DEF)
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic          i_wr_data,
    input  logic [AW-1:0] i_rd_addr,
    output logic          o_rd_data
);
    logic mem [DEPTH];
    logic r_rd;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        r_rd <= mem[i_rd_addr];
    end

    assign o_rd_data = r_rd;

endmodule

// ===== hdl/contiguous_page_frame_allocator_top.sv =====
// Contiguous page frame allocator: sequencer over a frame bitmap RAM and a divider.
//
// Requests enter on i_req when start is high and busy is low. An allocate rounds
// request_size up to whole pages, scans the bitmap from frame 0 for the first
// run of free frames of that length, marks it used and returns its start frame.
// A release clears the request_size pages, rounded up, from the frame holding
// release_address, clamped to the frame count, and always reports success.
// Each request yields one result on o_rsp, flagged by o_strobe for one cycle;
// the receiver takes it in that cycle and cannot hold it off.
// Registers are written on the cfg channel (index 0 page size, 1 frame count),
// always ready; the user writes them only while busy is low, which the block
// does not enforce. Per request, an allocate runs a division, a scan of the
// bitmap from frame 0 and a mark of each frame of the run; a release divides
// the address, then the size, and clears each frame in range. A failed size
// check ends right after the division. The bitmap RAM port sets the scan and
// mark rate. After reset the bitmap is cleared one frame per cycle, all
// NUM_FRAMES frames, with busy high; config writes are still taken during that pass.
module contiguous_page_frame_allocator_top #(
    parameter int NUM_FRAMES = cpfa_pkg::NUM_FRAMES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  cpfa_pkg::t_req               i_req,
    output logic                         o_strobe,
    output cpfa_pkg::t_rsp               o_rsp,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [cpfa_pkg::CFG_IW-1:0]  i_cfg_index,
    input  logic [cpfa_pkg::CFG_DW-1:0]  i_cfg_data
);
    import cpfa_pkg::*;

    localparam int FW = $clog2(NUM_FRAMES);
    localparam int CW = $clog2(NUM_FRAMES + 1);
    localparam int NW = (CW > FCNT_W) ? CW : FCNT_W;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV_ADDR,
        S_DIV_SIZE,
        S_SCAN,
        S_MARK,
        S_REL
    } t_state;

    t_state            r_state;
    logic              r_op;
    logic [SIZE_W-1:0] r_size;
    logic [ADDR_W-1:0] r_sp;
    logic [CW-1:0]     r_need;
    logic [CW-1:0]     r_run;
    logic [CW-1:0]     r_first;
    logic [CW-1:0]     r_ra;
    logic              r_rv;
    logic [CW-1:0]     r_ci;
    logic [CW-1:0]     r_wi;
    logic [CW-1:0]     r_end;
    logic              r_strobe;
    t_rsp              r_rsp;
    logic [PAGE_W-1:0] r_page;
    logic [FCNT_W-1:0] r_fcnt;

    t_div_req          div_req;
    t_div_rsp          div_rsp;
    logic              used;

    logic [PAGE_W-1:0] eff_page;
    logic [NW-1:0]     fc_ext;
    logic [NW-1:0]     nf_full;
    logic [CW-1:0]     nf;
    logic [SIZE_W:0]   need;
    logic [SIZE_W+1:0] rel_sum;
    logic [SIZE_W+1:0] rel_end;
    logic              rel_empty;
    logic [CW-1:0]     run_inc;
    logic              hit;
    logic [CW-1:0]     first_n;
    logic              last;
    logic [CW+START_W-1:0] first_ext;

    always_comb begin
        eff_page  = (r_page == '0) ? PAGE_W'(1) : r_page;
        fc_ext    = NW'(r_fcnt);
        nf_full   = (fc_ext > NW'(NUM_FRAMES)) ? NW'(NUM_FRAMES) : fc_ext;
        nf        = nf_full[CW-1:0];
        need      = {1'b0, div_rsp.quot} + (SIZE_W+1)'(div_rsp.rem_nz);
        rel_sum   = (SIZE_W+2)'(r_sp) + (SIZE_W+2)'(need);
        rel_end   = (rel_sum > (SIZE_W+2)'(nf)) ? (SIZE_W+2)'(nf) : rel_sum;
        rel_empty = (SIZE_W+2)'(r_sp) >= rel_end;
        run_inc   = r_run + 1'b1;
        hit       = !used && (run_inc == r_need);
        first_n   = (r_run == '0) ? r_ci : r_first;
        last      = r_ci == (nf - 1'b1);
        first_ext = {{START_W{1'b0}}, r_first};

        // launch a division on request accept, and size after address on release
        div_req.divisor  = eff_page;
        div_req.start    = 1'b0;
        div_req.dividend = r_size;
        if (r_state == S_IDLE && start) begin
            div_req.start    = 1'b1;
            div_req.dividend = (i_req.opcode == OP_RELEASE) ?
                               SIZE_W'(i_req.release_address) : i_req.request_size;
        end else if (r_state == S_DIV_ADDR && div_rsp.done) begin
            div_req.start    = 1'b1;
            div_req.dividend = r_size;
        end
    end

    cpfa_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    cpfa_bitmap #(
        .DEPTH (NUM_FRAMES),
        .AW    (FW)
    ) u_bitmap (
        .i_clk     (i_clk),
        .i_wr_en   (r_state == S_CLEAR || r_state == S_MARK || r_state == S_REL),
        .i_wr_addr (r_wi[FW-1:0]),
        .i_wr_data (r_state == S_MARK),
        .i_rd_addr (r_ra[FW-1:0]),
        .o_rd_data (used)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page <= PAGE_BYTES_RST;
            r_fcnt <= FRAME_COUNT_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_PAGE_BYTES:  r_page <= i_cfg_data;
                REG_FRAME_COUNT: r_fcnt <= i_cfg_data[FCNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_wi     <= '0;
            r_rv     <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            case (r_state)
                S_CLEAR: begin
                    r_wi <= r_wi + 1'b1;
                    if (r_wi == CW'(NUM_FRAMES - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (start) begin
                        r_op    <= i_req.opcode;
                        r_size  <= i_req.request_size;
                        r_state <= (i_req.opcode == OP_RELEASE) ? S_DIV_ADDR : S_DIV_SIZE;
                    end
                end
                S_DIV_ADDR: begin
                    if (div_rsp.done) begin
                        r_sp    <= div_rsp.quot[ADDR_W-1:0];
                        r_state <= S_DIV_SIZE;
                    end
                end
                S_DIV_SIZE: begin
                    if (div_rsp.done) begin
                        if (r_op == OP_ALLOC) begin
                            if (need == '0 || need > (SIZE_W+1)'(nf)) begin
                                r_strobe <= 1'b1;
                                r_rsp    <= '0;
                                r_state  <= S_IDLE;
                            end else begin
                                r_need  <= need[CW-1:0];
                                r_run   <= '0;
                                r_first <= '0;
                                r_ra    <= '0;
                                r_rv    <= 1'b0;
                                r_state <= S_SCAN;
                            end
                        end else if (rel_empty) begin
                            r_strobe          <= 1'b1;
                            r_rsp.success     <= 1'b1;
                            r_rsp.start_frame <= '0;
                            r_state           <= S_IDLE;
                        end else begin
                            r_wi    <= r_sp[CW-1:0];
                            r_end   <= rel_end[CW-1:0];
                            r_state <= S_REL;
                        end
                    end
                end
                S_SCAN: begin
                    // reads run one frame ahead of the run check
                    r_ra <= r_ra + 1'b1;
                    r_rv <= 1'b1;
                    r_ci <= r_ra;
                    if (r_rv) begin
                        r_run <= used ? '0 : run_inc;
                        if (!used) begin
                            r_first <= first_n;
                        end
                        if (hit) begin
                            r_wi    <= first_n;
                            r_state <= S_MARK;
                        end else if (last) begin
                            r_strobe <= 1'b1;
                            r_rsp    <= '0;
                            r_state  <= S_IDLE;
                        end
                    end
                end
                S_MARK: begin
                    r_wi   <= r_wi + 1'b1;
                    r_need <= r_need - 1'b1;
                    if (r_need == CW'(1)) begin
                        r_strobe          <= 1'b1;
                        r_rsp.success     <= 1'b1;
                        r_rsp.start_frame <= first_ext[START_W-1:0];
                        r_state           <= S_IDLE;
                    end
                end
                S_REL: begin
                    r_wi <= r_wi + 1'b1;
                    if (r_wi + 1'b1 == r_end) begin
                        r_strobe          <= 1'b1;
                        r_rsp.success     <= 1'b1;
                        r_rsp.start_frame <= '0;
                        r_state           <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy        = r_state != S_IDLE;
    assign o_strobe    = r_strobe;
    assign o_rsp       = r_rsp;
    assign o_cfg_ready = 1'b1;

endmodule

// ===== hdl/cpfa_chk.sv =====
// Port-level checks of the page frame allocator, bound to the top level.
module cpfa_chk (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           start,
    input logic           busy,
    input logic           o_strobe,
    input cpfa_pkg::t_rsp o_rsp
);
    import cpfa_pkg::*;

    // a result only closes a request that was in work
    a_strobe_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(busy))
        else $error("result without a request in work");

    a_accept_sets_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not raise busy");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("two results in a row");

    a_fail_zero_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_rsp.success) |-> (o_rsp.start_frame == '0))
        else $error("failed allocation with nonzero start frame");

endmodule

bind contiguous_page_frame_allocator_top cpfa_chk u_cpfa_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_strobe (o_strobe),
    .o_rsp    (o_rsp)
);
